// ===== hw/rtl/u8dv_pkg.sv =====
// shared types, constants and byte classification for the utf-8 decoder
`timescale 1ns / 1ps
`default_nettype none

package u8dv_pkg;

  // width of the internal character counter (saturates at all ones)
  localparam int COUNT_BITS = 32;
  localparam int CP_W       = 21;
  localparam int OUT_CNT_W  = 32;

  // byte patterns
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // kind of a byte seen with no sequence open
  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_kind_t;

  // one result item
  typedef struct packed {
    logic [CP_W-1:0]      code_point;
    logic                 code_point_ready;
    logic                 sequence_error;
    logic [OUT_CNT_W-1:0] char_count;
    logic                 text_valid;
    logic                 last_result;
  } out_item_t;

  // classify a byte as a lead
  function automatic lead_kind_t classify_lead(input logic [7:0] b);
    lead_kind_t k;
    k = LEAD_BAD;
    if (!b[7]) begin
      k = LEAD_ASCII;
    end else if (b[7:5] == LEAD2_TAG) begin
      k = LEAD_TWO;
    end else if (b[7:4] == LEAD3_TAG) begin
      k = LEAD_THREE;
    end else if (b[7:3] == LEAD4_TAG) begin
      k = LEAD_FOUR;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8dv_if.sv =====
// valid/ready channel interfaces for the byte input and the result output
`timescale 1ns / 1ps
`default_nettype none

interface u8dv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface u8dv_out_if;
  import u8dv_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CP_W-1:0]      code_point;
  logic                 code_point_ready;
  logic                 sequence_error;
  logic [OUT_CNT_W-1:0] char_count;
  logic                 text_valid;
  logic                 last_result;

  modport source (output valid, output code_point, output code_point_ready,
                  output sequence_error, output char_count, output text_valid,
                  output last_result, input ready);
  modport sink   (input valid, input code_point, input code_point_ready,
                  input sequence_error, input char_count, input text_valid,
                  input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dv_step.sv =====
// decoder state and the per-byte decode logic
`timescale 1ns / 1ps
`default_nettype none

module u8dv_step
  import u8dv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_text,
  output out_item_t       res
);

  logic [1:0]            need_r, need_nxt;
  logic [CP_W-1:0]       pv_r, pv_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  noerr_r, noerr_nxt;

  logic                  is_cont;
  logic                  err;
  logic                  rdy;
  logic [CP_W-1:0]       cp;
  logic [1:0]            need_d;
  logic [CP_W-1:0]       pv_d;
  lead_kind_t            kind;

  assign is_cont = (in_byte[7:6] == CONT_TAG);
  assign kind    = classify_lead(in_byte);

  // decode one byte against the open sequence
  always_comb begin
    err    = 1'b0;
    rdy    = 1'b0;
    cp     = '0;
    need_d = need_r;
    pv_d   = pv_r;
    if ((need_r != 2'd0) && is_cont) begin
      need_d = need_r - 2'd1;
      pv_d   = {pv_r[CP_W-7:0], in_byte[5:0]};
      if (need_d == 2'd0) begin
        rdy  = 1'b1;
        cp   = pv_d;
        pv_d = '0;
      end
    end else begin
      // an open sequence cut short by a non-continuation byte
      err    = (need_r != 2'd0);
      need_d = 2'd0;
      pv_d   = '0;
      unique case (kind)
        LEAD_ASCII: begin
          rdy = 1'b1;
          cp  = CP_W'(in_byte[6:0]);
        end
        LEAD_TWO: begin
          need_d = 2'd1;
          pv_d   = CP_W'(in_byte[4:0]);
        end
        LEAD_THREE: begin
          need_d = 2'd2;
          pv_d   = CP_W'(in_byte[3:0]);
        end
        LEAD_FOUR: begin
          need_d = 2'd3;
          pv_d   = CP_W'(in_byte[2:0]);
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end
    // truncated at end of buffer
    if (end_of_text && (need_d != 2'd0)) begin
      err = 1'b1;
    end
  end

  // running count and flag, then clear after the last byte
  always_comb begin
    cnt_nxt   = cnt_r;
    if (rdy && (cnt_r != {COUNT_BITS{1'b1}})) begin
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
    noerr_nxt = noerr_r & ~err;

    res.code_point       = cp;
    res.code_point_ready = rdy;
    res.sequence_error   = err;
    res.char_count       = OUT_CNT_W'(cnt_nxt);
    res.text_valid       = noerr_nxt;
    res.last_result      = end_of_text;
  end

  assign need_nxt = end_of_text ? 2'd0 : need_d;
  assign pv_nxt   = end_of_text ? '0   : pv_d;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r  <= 2'd0;
      pv_r    <= '0;
      cnt_r   <= '0;
      noerr_r <= 1'b1;
    end else if (acc) begin
      need_r  <= need_nxt;
      pv_r    <= pv_nxt;
      cnt_r   <= end_of_text ? '0   : cnt_nxt;
      noerr_r <= end_of_text ? 1'b1 : noerr_nxt;
    end
  end

  // buffer end returns all state to its reset value
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && end_of_text |=> (need_r == 2'd0) && (cnt_r == '0) && noerr_r)
    else $error("state not cleared after last byte");

  // no partial value is left without an open sequence
  a_pv_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r == 2'd0) |-> (pv_r == '0))
    else $error("partial value without open sequence");

  // an error inside a buffer sticks until the buffer ends
  a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    acc && err && !end_of_text |=> !noerr_r)
    else $error("error flag lost inside buffer");

endmodule

`default_nettype wire

// ===== hw/rtl/u8dv_skid.sv =====
// two-entry output buffer whose can_push comes from its own state, not directly from out ready
`timescale 1ns / 1ps
`default_nettype none

module u8dv_skid
  import u8dv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  output logic           can_push,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      main_valid_r, skid_valid_r;
  out_item_t main_r, skid_r;
  logic      pop;

  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_item  = main_r;
  assign pop       = main_valid_r & out_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        main_valid_r <= skid_valid_r | push;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= main_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_valid_r ? skid_r : push_item;
    end else if (push && !main_valid_r) begin
      main_r <= push_item;
    end
    if (push && main_valid_r && !pop) begin
      skid_r <= push_item;
    end
  end

  // the spare entry is only used behind a full main entry
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("spare entry filled with main entry empty");

  // a stalled full buffer keeps its spare item
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !pop |=> skid_valid_r && $stable(skid_r))
    else $error("spare item lost during stall");

  // a pop with a spare item leaves the buffer holding one item
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> main_valid_r && !skid_valid_r)
    else $error("drain of spare entry broken");

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decode_validate_top.sv =====
// top level of the streaming utf-8 decoder and validator
//
//   channel   direction  payload
//   in_ch     sink       in_byte[7:0], end_of_text
//   out_ch    source     code_point[20:0], code_point_ready, sequence_error,
//                        char_count[31:0], text_valid, last_result
//
// one byte item accepted per cycle while in_ready is high; its result item is
// registered in the output buffer and offered behind any earlier result; the
// decode state updates as each byte is taken, so bytes follow back to back.
// a two-entry output buffer lets input run while one result waits; in_ready
// drops only when both entries are full.
// rst_n is synchronous, active low; it clears decode state and the buffer.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decode_validate_top
  import u8dv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  u8dv_in_if.sink     in_ch,
  u8dv_out_if.source  out_ch
);

  logic      acc;
  logic      can_push;
  out_item_t step_res;
  out_item_t buf_item;

  assign in_ch.ready = can_push;
  assign acc         = in_ch.valid & can_push;

  // per-byte decode
  u8dv_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .in_byte     (in_ch.in_byte),
    .end_of_text (in_ch.end_of_text),
    .res         (step_res)
  );

  // result buffer
  u8dv_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_item (step_res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (buf_item)
  );

  assign out_ch.code_point       = buf_item.code_point;
  assign out_ch.code_point_ready = buf_item.code_point_ready;
  assign out_ch.sequence_error   = buf_item.sequence_error;
  assign out_ch.char_count       = buf_item.char_count;
  assign out_ch.text_valid       = buf_item.text_valid;
  assign out_ch.last_result      = buf_item.last_result;

endmodule

`default_nettype wire
